// ----- rtl/gmps_pkg.sv -----
package gmps_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_DATA_WIDTH = 16;
  localparam int DEF_SUM_WIDTH  = 32;

  // Column-count register.
  localparam int                   CFG_WIDTH      = 11;
  localparam logic [CFG_WIDTH-1:0] NUM_COLS_RESET = CFG_WIDTH'(1024);

  // Per-cell control flags handed from the column tracker to the update stage.
  typedef struct packed {
    logic first_row;  // cell belongs to the first row of the matrix
    logic col_zero;   // cell sits in column zero
    logic last_col;   // cell closes its row
    logic exact_end;  // cell sits exactly in the last column
    logic eom;        // cell carries the end-of-matrix mark
  } cell_ctl_t;

  // Status of the update stage, seen by the top level.
  typedef struct packed {
    logic valid;    // a cell is held in the update stage
    logic eom;      // that cell ends the matrix
    logic advance;  // the cell retires in this cycle
  } stage_stat_t;

endpackage

// ----- rtl/gmps_cell_if.sv -----
interface gmps_cell_if #(
  parameter int DATA_WIDTH = gmps_pkg::DEF_DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] cell_value;
  logic                         end_of_matrix;

  modport source (output valid, output cell_value, output end_of_matrix, input ready);
  modport sink (input valid, input cell_value, input end_of_matrix, output ready);
endinterface

// ----- rtl/gmps_sum_if.sv -----
interface gmps_sum_if #(
  parameter int SUM_WIDTH = gmps_pkg::DEF_SUM_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic signed [SUM_WIDTH-1:0] max_sum;
  logic                        incomplete_row;

  modport source (output valid, output max_sum, output incomplete_row, input ready);
  modport sink (input valid, input max_sum, input incomplete_row, output ready);
endinterface

// ----- rtl/gmps_ram.sv -----
module gmps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/gmps_col_ctrl.sv -----
module gmps_col_ctrl #(
  parameter int MAX_COLS = gmps_pkg::DEF_MAX_COLS,
  parameter int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gmps_pkg::CFG_WIDTH-1:0]   cfg_wdata,
  input  logic                             accept,
  input  logic                             eom,
  output logic [COL_W-1:0]                 col,
  output logic [COL_W-1:0]                 rd_addr,
  output gmps_pkg::cell_ctl_t              ctl
);
  import gmps_pkg::*;

  localparam int CNT_W = $clog2(MAX_COLS + 1);

  logic [CFG_WIDTH-1:0] num_cols;
  logic [COL_W-1:0]     col_index, col_index_next;
  logic                 first_row, first_row_next;
  logic [31:0]          cols_wide;
  logic [CNT_W-1:0]     eff_cols;
  logic [CNT_W-1:0]     col_plus1;
  logic                 last_col;

  // Column-count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= NUM_COLS_RESET;
    end else if (cfg_we) begin
      num_cols <= cfg_wdata;
    end
  end

  // A count of zero acts as one; a count above the row buffer is clamped.
  always_comb begin
    cols_wide = 32'(num_cols);
    if (cols_wide == 32'd0) begin
      eff_cols = CNT_W'(1);
    end else if (cols_wide > 32'(MAX_COLS)) begin
      eff_cols = CNT_W'(MAX_COLS);
    end else begin
      eff_cols = CNT_W'(cols_wide);
    end
  end

  // Row position of the cell at the input and the read-ahead address.
  // The last cell of a row fetches column zero for the next row.
  always_comb begin
    col_plus1     = CNT_W'(col_index) + CNT_W'(1);
    last_col      = (col_plus1 >= eff_cols);
    rd_addr       = last_col ? '0 : COL_W'(col_plus1);
    col           = col_index;
    ctl.first_row = first_row;
    ctl.col_zero  = (col_index == '0);
    ctl.last_col  = last_col;
    ctl.exact_end = (col_plus1 == eff_cols);
    ctl.eom       = eom;
  end

  // Advance the column on every accepted beat; the end mark starts a new matrix.
  always_comb begin
    col_index_next = col_index;
    first_row_next = first_row;
    if (accept) begin
      if (eom) begin
        col_index_next = '0;
        first_row_next = 1'b1;
      end else if (last_col) begin
        col_index_next = '0;
        first_row_next = 1'b0;
      end else begin
        col_index_next = COL_W'(col_plus1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_index <= '0;
      first_row <= 1'b1;
    end else begin
      col_index <= col_index_next;
      first_row <= first_row_next;
    end
  end

endmodule

// ----- rtl/gmps_update.sv -----
module gmps_update #(
  parameter int MAX_COLS   = gmps_pkg::DEF_MAX_COLS,
  parameter int DATA_WIDTH = gmps_pkg::DEF_DATA_WIDTH,
  parameter int SUM_WIDTH  = gmps_pkg::DEF_SUM_WIDTH,
  parameter int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  gmps_pkg::cell_ctl_t          ctl_in,
  input  logic [COL_W-1:0]             col_in,
  input  logic [COL_W-1:0]             rd_addr,
  input  logic signed [DATA_WIDTH-1:0] value_in,
  input  logic [SUM_WIDTH-1:0]         ram_rdata,
  output logic                         wr_en,
  output logic [COL_W-1:0]             wr_addr,
  output logic [SUM_WIDTH-1:0]         wr_data,
  output gmps_pkg::stage_stat_t        stat,
  gmps_sum_if.source                   sums
);
  import gmps_pkg::*;

  localparam int EXT_W = ((DATA_WIDTH > SUM_WIDTH) ? DATA_WIDTH : SUM_WIDTH) + 2;
  localparam logic signed [EXT_W-1:0] SUM_MAX_EXT =
    (EXT_W'(1) <<< (SUM_WIDTH - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] SUM_MIN_EXT = -SUM_MAX_EXT - EXT_W'(1);
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH - 1){1'b0}}};

  // Stage registers for the cell under update.
  logic                         b_valid;
  cell_ctl_t                    b_ctl;
  logic [COL_W-1:0]             b_col;
  logic signed [DATA_WIDTH-1:0] b_value;
  logic                         fwd_hit;
  logic signed [SUM_WIDTH-1:0]  fwd_data;

  // Previous-row sums around the current column, and the running row maximum.
  logic signed [SUM_WIDTH-1:0]  up_sum;
  logic signed [SUM_WIDTH-1:0]  left_sum;
  logic signed [SUM_WIDTH-1:0]  row_best;

  logic                         advance;
  logic signed [SUM_WIDTH-1:0]  ahead_sum;
  logic signed [SUM_WIDTH-1:0]  best;
  logic signed [EXT_W-1:0]      total;
  logic signed [SUM_WIDTH-1:0]  sum;
  logic                         new_best;
  logic signed [SUM_WIDTH-1:0]  best_out;

  // The stage retires unless an end cell meets a full, untaken result register.
  assign advance = b_valid && (!b_ctl.eom || !sums.valid || sums.ready);

  assign stat.valid   = b_valid;
  assign stat.eom     = b_ctl.eom;
  assign stat.advance = advance;

  // Pick the best reachable neighbor and add the cell with saturation.
  always_comb begin
    ahead_sum = fwd_hit ? fwd_data : $signed(ram_rdata);
    best      = up_sum;
    if (!b_ctl.col_zero && (left_sum > best)) begin
      best = left_sum;
    end
    if (!b_ctl.last_col && (ahead_sum > best)) begin
      best = ahead_sum;
    end
    if (b_ctl.first_row) begin
      best = '0;
    end
    total = EXT_W'(best) + EXT_W'(b_value);
    if (total > SUM_MAX_EXT) begin
      sum = SUM_WIDTH'(SUM_MAX_EXT);
    end else if (total < SUM_MIN_EXT) begin
      sum = SUM_MIN;
    end else begin
      sum = SUM_WIDTH'(total);
    end
    new_best = b_ctl.col_zero || (sum > row_best);
    best_out = new_best ? sum : row_best;
  end

  // Write back the new sum of this column.
  assign wr_en   = advance;
  assign wr_addr = b_col;
  assign wr_data = sum;

  // Load the stage on an accepted beat. A read that hits the entry being
  // written in the same cycle takes the new sum instead of the memory data.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (advance) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_ctl    <= ctl_in;
      b_col    <= col_in;
      b_value  <= value_in;
      fwd_hit  <= b_valid && (b_col == rd_addr);
      fwd_data <= sum;
    end
  end

  // Neighbor registers shift by one column per retired cell. A one-cell row
  // feeds its own sum forward as the next row's upper neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      up_sum   <= '0;
      left_sum <= '0;
      row_best <= SUM_MIN;
    end else if (advance) begin
      up_sum   <= (b_ctl.last_col && b_ctl.col_zero) ? sum : ahead_sum;
      left_sum <= up_sum;
      row_best <= b_ctl.eom ? SUM_MIN : best_out;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sums.valid <= 1'b0;
    end else if (advance && b_ctl.eom) begin
      sums.valid <= 1'b1;
    end else if (sums.ready) begin
      sums.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b_ctl.eom) begin
      sums.max_sum        <= best_out;
      sums.incomplete_row <= !b_ctl.exact_end;
    end
  end

endmodule

// ----- rtl/grid_max_path_sum_dp.sv -----
// Streaming maximum path sum through a matrix where each step moves one row
// down, straight or one column diagonally.
// Channels: cells (sink) takes one beat per matrix cell in row-major order,
// carrying cell_value and end_of_matrix. sums (source) gives one beat per
// matrix, on the cell marked end_of_matrix: max_sum is the largest saturated
// path sum in the final row and incomplete_row is set if that cell was not
// in the last column. cfg_we/cfg_wdata write the column count (1 to
// MAX_COLS; zero acts as one, larger values as MAX_COLS) while idle.
// Throughput: one cell per cycle unless an end cell stalls. Each cell reads the
// previous row's sum one column ahead from the row buffer in the cycle it is
// accepted and writes its own sum back when it retires; a same-entry read and
// write is bypassed. The result beat is registered when the end cell retires.
// Stall: cells keep flowing while a result waits; only an end cell that finds
// the result register still full stops the input until sums is taken.
// Reset: column count returns to 1024 and a new matrix begins. The row buffer
// is not cleared and needs no clearing pass.
module grid_max_path_sum_dp #(
  parameter int MAX_COLS   = gmps_pkg::DEF_MAX_COLS,
  parameter int DATA_WIDTH = gmps_pkg::DEF_DATA_WIDTH,
  parameter int SUM_WIDTH  = gmps_pkg::DEF_SUM_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gmps_pkg::CFG_WIDTH-1:0] cfg_wdata,
  gmps_cell_if.sink                      cells,
  gmps_sum_if.source                     sums
);
  import gmps_pkg::*;

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic                 in_accept;
  logic [COL_W-1:0]     col;
  logic [COL_W-1:0]     rd_addr;
  cell_ctl_t            ctl;
  logic [SUM_WIDTH-1:0] ram_rdata;
  logic                 wr_en;
  logic [COL_W-1:0]     wr_addr;
  logic [SUM_WIDTH-1:0] wr_data;
  stage_stat_t          stat;

  // Input handshake: take a beat whenever the update stage can move on.
  assign cells.ready = !stat.valid || stat.advance;
  assign in_accept   = cells.valid && cells.ready;

  // Column tracking and read-ahead address.
  gmps_col_ctrl #(
    .MAX_COLS (MAX_COLS),
    .COL_W    (COL_W)
  ) u_col_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (in_accept),
    .eom       (cells.end_of_matrix),
    .col       (col),
    .rd_addr   (rd_addr),
    .ctl       (ctl)
  );

  // Row buffer of best path sums.
  gmps_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (MAX_COLS),
    .AW    (COL_W)
  ) u_row_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Sum update, write-back and result register.
  gmps_update #(
    .MAX_COLS   (MAX_COLS),
    .DATA_WIDTH (DATA_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH),
    .COL_W      (COL_W)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .ctl_in    (ctl),
    .col_in    (col),
    .rd_addr   (rd_addr),
    .value_in  (cells.cell_value),
    .ram_rdata (ram_rdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .stat      (stat),
    .sums      (sums)
  );

`ifndef SYNTHESIS
  // Every accepted beat occupies the update stage in the next cycle.
  assert property (@(posedge clk) disable iff (rst) in_accept |=> stat.valid)
    else $error("accepted cell did not reach the update stage");

  // A result appears only after an end cell retired from the update stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(sums.valid) |-> $past(stat.valid && stat.eom && stat.advance))
    else $error("result beat without a retired end cell");

  // An end cell blocked by a full result register holds off the input.
  assert property (@(posedge clk) disable iff (rst)
    (stat.valid && stat.eom && sums.valid && !sums.ready) |-> !cells.ready)
    else $error("input taken while an end cell is blocked");
`endif

endmodule

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gmps_pkg::*;

  localparam int     MAX_COLS     = DEF_MAX_COLS;
  localparam int     DW           = DEF_DATA_WIDTH;
  localparam int     SW           = DEF_SUM_WIDTH;
  localparam longint SUM_HI       = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SUM_LO       = -SUM_HI - 1;
  localparam int     QUIET_LIMIT  = 3000;
  localparam int     RANDOM_CELLS = 1100;
  localparam int     SETTLE_TICKS = 8;

  typedef struct packed {
    logic signed [SW-1:0] max_sum;
    logic                 incomplete_row;
  } sum_beat_t;

  // Tracks the best path sums row by row and holds the result beats still owed.
  class path_sum_board;
    longint                row_sums[MAX_COLS];
    int unsigned           col;
    bit                    first_row;
    longint                left_up;
    longint                row_best;
    logic [CFG_WIDTH-1:0]  cols_reg;
    sum_beat_t             expected_sums[$];
    int unsigned           failures;

    function new();
      foreach (row_sums[i]) row_sums[i] = 0;
      cols_reg = NUM_COLS_RESET;
      failures = 0;
      start_matrix();
    endfunction

    function void start_matrix();
      col       = 0;
      first_row = 1'b1;
      left_up   = 0;
      row_best  = SUM_LO;
    endfunction

    // Zero acts as one column; anything past the buffer size acts as the buffer size.
    function int unsigned active_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return 32'(cols_reg);
    endfunction

    function void take_cell(logic signed [DW-1:0] v, logic eom);
      int unsigned m;
      int unsigned c;
      longint      up;
      longint      pick;
      longint      s;
      sum_beat_t   beat;
      m  = active_cols();
      c  = col;
      up = row_sums[c];
      if (first_row) begin
        s = longint'(v);
      end else begin
        // Best of up-left, up and up-right, skipping neighbors outside the row.
        pick = up;
        if (c > 0 && left_up > pick) pick = left_up;
        if (c + 1 < m && row_sums[c + 1] > pick) pick = row_sums[c + 1];
        s = pick + longint'(v);
        if (s > SUM_HI) s = SUM_HI;
        else if (s < SUM_LO) s = SUM_LO;
      end
      left_up     = up;
      row_sums[c] = s;
      if (c == 0 || s > row_best) row_best = s;
      if (eom) begin
        beat.max_sum        = SW'(row_best);
        beat.incomplete_row = (c + 1 != m);
        expected_sums.push_back(beat);
        start_matrix();
      end else if (c + 1 >= m) begin
        col       = 0;
        first_row = 1'b0;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_sum(logic signed [SW-1:0] got_sum, logic got_inc);
      sum_beat_t want;
      if (expected_sums.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected sum beat: max_sum %0d incomplete_row %0b", got_sum, got_inc);
        return;
      end
      want = expected_sums.pop_front();
      if (got_sum !== want.max_sum || got_inc !== want.incomplete_row) begin
        failures++;
        if (failures <= 10)
          $display("sum beat mismatch: max_sum exp %0d got %0d, incomplete_row exp %0b got %0b",
                   want.max_sum, got_sum, want.incomplete_row, got_inc);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_WIDTH-1:0] cfg_wdata;
  int unsigned          idle_pct     = 0;
  int unsigned          stall_pct    = 0;
  int unsigned          cells_sent   = 0;
  int unsigned          quiet_cycles = 0;
  path_sum_board        board;

  gmps_cell_if #(.DATA_WIDTH(DW)) cell_bus();
  gmps_sum_if  #(.SUM_WIDTH(SW))  sum_bus();

  grid_max_path_sum_dp #(
    .MAX_COLS(MAX_COLS),
    .DATA_WIDTH(DW),
    .SUM_WIDTH(SW)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .cells(cell_bus),
    .sums(sum_bus)
  );

  // Free-running 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side back-pressure.
  initial begin
    sum_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      sum_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every accepted result beat.
  always @(posedge clk) begin
    if (!rst && sum_bus.valid && sum_bus.ready)
      board.check_sum(sum_bus.max_sum, sum_bus.incomplete_row);
  end

  // Give up when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (cell_bus.valid && cell_bus.ready) || (sum_bus.valid && sum_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(7))
      0:       return {1'b0, {(DW - 1){1'b1}}};
      1:       return {1'b1, {(DW - 1){1'b0}}};
      2:       return DW'($urandom_range(0, 3));
      default: return DW'($urandom);
    endcase
  endfunction

  // Mostly narrow matrices, now and then the out-of-range and widest settings.
  function automatic logic [CFG_WIDTH-1:0] pick_cols();
    case ($urandom_range(19))
      0:       return '0;
      1:       return CFG_WIDTH'(MAX_COLS);
      2:       return CFG_WIDTH'($urandom_range(MAX_COLS + 1, (1 << CFG_WIDTH) - 1));
      3, 4:    return CFG_WIDTH'($urandom_range(9, 40));
      default: return CFG_WIDTH'($urandom_range(1, 8));
    endcase
  endfunction

  // Send one cell beat, with random idle cycles ahead of it.
  task automatic send_cell(input logic signed [DW-1:0] v, input logic eom);
    while ($urandom_range(99) < idle_pct) begin
      cell_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cell_bus.valid         <= 1'b1;
    cell_bus.cell_value    <= v;
    cell_bus.end_of_matrix <= eom;
    @(posedge clk);
    while (!cell_bus.ready) @(posedge clk);
    board.take_cell(v, eom);
    cells_sent++;
  endtask

  // Wait for every owed result, then let the pipeline empty.
  task automatic drain_sums();
    while (board.expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_cols(input logic [CFG_WIDTH-1:0] value);
    cell_bus.valid <= 1'b0;
    drain_sums();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.cols_reg = value;
  endtask

  task automatic set_phase(input int unsigned n);
    case (n % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 81; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 81; end
      default: begin idle_pct = 33; stall_pct = 33; end
    endcase
  endtask

  // One matrix of whole rows, sometimes cut short, sometimes with a column
  // change partway. After the first row only narrowing is allowed, so no cell
  // ever reads a row entry that was never written.
  task automatic run_matrix();
    int unsigned m;
    int unsigned len;
    int unsigned cut;
    m = board.active_cols();
    if (m > 64) begin
      len = $urandom_range(1, 20);
    end else begin
      len = $urandom_range(1, 4) * m;
      if ($urandom_range(3) == 0) len = $urandom_range(1, len);
    end
    cut = ($urandom_range(9) == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
    for (int unsigned k = 0; k < len; k++) begin
      if (cut != 0 && k == cut) begin
        if (board.first_row) write_cols(pick_cols());
        else write_cols(CFG_WIDTH'($urandom_range(0, board.active_cols())));
      end
      send_cell(pick_value(), k == len - 1);
    end
  endtask

  initial begin
    int unsigned matrices;
    board                  = new();
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    cell_bus.valid         = 1'b0;
    cell_bus.cell_value    = '0;
    cell_bus.end_of_matrix = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Single-cell matrices at the reset column count, both value extremes.
    send_cell(16'sh7FFF, 1'b1);
    send_cell(16'sh8000, 1'b1);

    // Full 3x3 matrix ending exactly on the last column.
    write_cols(11'd3);
    send_cell(16'sd5, 1'b0);
    send_cell(16'sh8000, 1'b0);
    send_cell(16'sh7FFF, 1'b0);
    send_cell(-16'sd1, 1'b0);
    send_cell(16'sd0, 1'b0);
    send_cell(16'sd7, 1'b0);
    send_cell(16'sh7FFF, 1'b0);
    send_cell(16'sh8000, 1'b0);
    send_cell(16'sd1, 1'b1);

    // End mark in the first column of a new row: incomplete final row.
    send_cell(16'sd100, 1'b0);
    send_cell(-16'sd100, 1'b0);
    send_cell(16'sd3, 1'b0);
    send_cell(-16'sd7, 1'b1);

    // Zero columns acts as a single column.
    write_cols(11'd0);
    send_cell(-16'sd5, 1'b0);
    send_cell(-16'sd6, 1'b0);
    send_cell(16'sd9, 1'b1);

    // Narrowing partway through a row: the cell past the new last column closes it.
    write_cols(11'd3);
    send_cell(16'sd10, 1'b0);
    send_cell(16'sd20, 1'b0);
    send_cell(16'sd30, 1'b0);
    send_cell(-16'sd4, 1'b0);
    send_cell(16'sd8, 1'b0);
    write_cols(11'd1);
    send_cell(16'sd2, 1'b0);
    send_cell(-16'sd3, 1'b1);

    // Random matrices across the idle and stall phases.
    matrices = 0;
    while (cells_sent < RANDOM_CELLS) begin
      set_phase(matrices / 5);
      if ($urandom_range(2) == 0) write_cols(pick_cols());
      run_matrix();
      matrices++;
    end

    cell_bus.valid <= 1'b0;
    drain_sums();
    if (board.failures == 0 && board.expected_sums.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/gmps_pkg.sv
rtl/gmps_cell_if.sv
rtl/gmps_sum_if.sv
rtl/gmps_ram.sv
rtl/gmps_col_ctrl.sv
rtl/gmps_update.sv
rtl/grid_max_path_sum_dp.sv
verif/testbench.sv
